/* hdl/serial_api_frame_parser_core_defines.svh */
// Assertion macros for the serial API frame parser.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SERIAL_API_FRAME_PARSER_CORE_DEFINES_SVH
`define SERIAL_API_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, gated by reset
`define SAFP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("safp same-cycle check failed");

// Next-cycle implication, gated by reset
`define SAFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("safp next-cycle check failed");

`endif

/* hdl/safp_pkg.sv */
// Shared types and constants of the serial API frame parser.
// No dependencies; imported by safp_ctrl, safp_dp and the top level.
package safp_pkg;

	// Result event codes
	typedef enum logic [2:0] {
		EV_DATA    = 3'd0,
		EV_OK      = 3'd1,
		EV_CHK_ERR = 3'd2,
		EV_LEN_ERR = 3'd3,
		EV_ACK     = 3'd4,
		EV_NAK     = 3'd5,
		EV_CAN     = 3'd6,
		EV_STRAY   = 3'd7
	} event_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SOF   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

	// Register reset values
	localparam logic [7:0] SOF_RST   = 8'h01;
	localparam logic [7:0] ACK_RST   = 8'h06;
	localparam logic [7:0] NAK_RST   = 8'h15;
	localparam logic [7:0] CAN_RST   = 8'h18;
	localparam logic [5:0] LIMIT_RST = 6'd32;

	// Frame constants
	localparam logic [7:0] CHK_INIT  = 8'hFF;
	localparam logic [7:0] LEN_OVHD  = 8'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic   pop;       // consume held byte
		logic   ld_len;    // latch length, seed checksum
		logic   ld_type;
		logic   ld_cmd;
		logic   st_data;   // write byte into frame store
		logic   rd_en;     // read store at release index
		logic   idx_inc;
		logic   emit;      // load output register
		event_t emit_ev;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic byte_avail;
		logic slot_free;
		logic is_ack;
		logic is_nak;
		logic is_can;
		logic is_sof;
		logic len_bad;
		logic dcount_zero;
		logic data_done;
		logic check_ok;
		logic rel_last;
	} dp_stat_t;

endpackage

/* hdl/safp_ctrl.sv */
// Frame parser controller: phase state machine that sequences the datapath.
// Depends on safp_pkg (command and status structs, event codes).
module safp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  safp_pkg::dp_stat_t    stat,
	output safp_pkg::ctrl_cmd_t   cmd
);
	import safp_pkg::*;

	typedef enum logic [3:0] {
		S_HUNT, S_LEN, S_TYPE, S_CMD, S_DATA, S_CHECK, S_RD, S_EMIT, S_OK
	} state_t;

	state_t state_q, state_d;
	logic   go;

	// A byte is handled only when one is held and the output slot is free
	assign go = stat.byte_avail && stat.slot_free;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		cmd.emit_ev = EV_DATA;
		state_d = state_q;
		case (state_q)
			S_HUNT: begin
				if (go) begin
					cmd.pop = 1'b1;
					if (stat.is_ack) begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_ACK;
					end else if (stat.is_nak) begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_NAK;
					end else if (stat.is_can) begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_CAN;
					end else if (stat.is_sof) begin
						state_d = S_LEN;
					end else begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_STRAY;
					end
				end
			end
			S_LEN: begin
				if (go) begin
					cmd.pop = 1'b1;
					if (stat.len_bad) begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_LEN_ERR;
						state_d = S_HUNT;
					end else begin
						cmd.ld_len = 1'b1;
						state_d = S_TYPE;
					end
				end
			end
			S_TYPE: begin
				if (go) begin
					cmd.pop = 1'b1;
					cmd.ld_type = 1'b1;
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				if (go) begin
					cmd.pop = 1'b1;
					cmd.ld_cmd = 1'b1;
					state_d = stat.dcount_zero ? S_CHECK : S_DATA;
				end
			end
			S_DATA: begin
				if (go) begin
					cmd.pop = 1'b1;
					cmd.st_data = 1'b1;
					if (stat.data_done) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (go) begin
					cmd.pop = 1'b1;
					if (!stat.check_ok) begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_CHK_ERR;
						state_d = S_HUNT;
					end else if (stat.dcount_zero) begin
						cmd.emit = 1'b1;
						cmd.emit_ev = EV_OK;
						state_d = S_HUNT;
					end else begin
						state_d = S_RD;
					end
				end
			end
			// Release: one store read, then one data result
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_ev = EV_DATA;
					cmd.idx_inc = 1'b1;
					state_d = stat.rel_last ? S_OK : S_RD;
				end
			end
			S_OK: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_ev = EV_OK;
					state_d = S_HUNT;
				end
			end
			default: begin
				state_d = S_HUNT;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/safp_dp.sv */
// Frame parser datapath: input hold, config registers, checksum, frame
// store and output register. Depends on safp_pkg.
module safp_dp #(
	parameter int unsigned MAX_DATA = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [safp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	// input request
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	// result request
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     event_res,
	output logic [7:0]                     frame_type,
	output logic [7:0]                     command,
	output logic [7:0]                     data_byte,
	output logic [4:0]                     data_index,
	output logic [5:0]                     data_count,
	output logic                           last,
	// controller link
	input  safp_pkg::ctrl_cmd_t            cmd,
	output safp_pkg::dp_stat_t             stat
);
	import safp_pkg::*;

	localparam int         IDX_W   = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam logic [5:0] MAX_CNT = 6'(MAX_DATA);

	// config registers
	logic [7:0] sof_q, ack_q, nak_q, can_q;
	logic [5:0] limit_q;

	// input hold
	logic [7:0] rx_q;
	logic       in_full_q;

	// frame state
	logic [7:0] type_q, cmd_q, chk_q, rd_q;
	logic [5:0] dcount_q, stored_q, idx_q;
	logic [7:0] mem_q [MAX_DATA];

	// output register
	logic       out_valid_q;
	event_t     ev_q;
	logic [7:0] ty_o_q, cm_o_q, db_o_q;
	logic [4:0] di_o_q;
	logic [5:0] dc_o_q;
	logic       last_o_q;

	logic [5:0] limit_eff;
	logic [7:0] len_max;
	logic       slot_free;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_q   <= SOF_RST;
			ack_q   <= ACK_RST;
			nak_q   <= NAK_RST;
			can_q   <= CAN_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SOF:   sof_q   <= cfg_data;
				REG_ACK:   ack_q   <= cfg_data;
				REG_NAK:   nak_q   <= cfg_data;
				REG_CAN:   can_q   <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// One-byte input hold
	assign in_ready = !in_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_full_q <= 1'b1;
		end else if (cmd.pop) begin
			in_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_q <= rx_byte;
		end
	end

	// Length limit: smaller of register and store depth
	assign limit_eff = (limit_q > MAX_CNT) ? MAX_CNT : limit_q;
	assign len_max   = {2'b00, limit_eff} + LEN_OVHD;
	assign slot_free = !out_valid_q || out_ready;

	// Status toward the controller
	always_comb begin
		stat.byte_avail  = in_full_q;
		stat.slot_free   = slot_free;
		stat.is_ack      = (rx_q == ack_q);
		stat.is_nak      = (rx_q == nak_q);
		stat.is_can      = (rx_q == can_q);
		stat.is_sof      = (rx_q == sof_q);
		stat.len_bad     = (rx_q < LEN_OVHD) || (rx_q > len_max);
		stat.dcount_zero = (dcount_q == 6'd0);
		stat.data_done   = ({1'b0, stored_q} + 7'd1) >= {1'b0, dcount_q};
		stat.check_ok    = (rx_q == chk_q);
		stat.rel_last    = ({1'b0, idx_q} + 7'd1) == {1'b0, dcount_q};
	end

	// Frame header, checksum and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.ld_len) begin
				stored_q <= '0;
				idx_q    <= '0;
			end else begin
				if (cmd.st_data) begin
					stored_q <= stored_q + 6'd1;
				end
				if (cmd.idx_inc) begin
					idx_q <= idx_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_len) begin
			dcount_q <= 6'(rx_q - LEN_OVHD);
			chk_q    <= CHK_INIT ^ rx_q;
		end
		if (cmd.ld_type) begin
			type_q <= rx_q;
			chk_q  <= chk_q ^ rx_q;
		end
		if (cmd.ld_cmd) begin
			cmd_q <= rx_q;
			chk_q <= chk_q ^ rx_q;
		end
		if (cmd.st_data) begin
			chk_q <= chk_q ^ rx_q;
		end
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.st_data && (stored_q < MAX_CNT)) begin
			mem_q[stored_q[IDX_W-1:0]] <= rx_q;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[idx_q[IDX_W-1:0]];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ev_q     <= cmd.emit_ev;
			ty_o_q   <= '0;
			cm_o_q   <= '0;
			db_o_q   <= '0;
			di_o_q   <= '0;
			dc_o_q   <= '0;
			last_o_q <= 1'b1;
			case (cmd.emit_ev)
				EV_DATA: begin
					ty_o_q   <= type_q;
					cm_o_q   <= cmd_q;
					db_o_q   <= rd_q;
					di_o_q   <= idx_q[4:0];
					dc_o_q   <= dcount_q;
					last_o_q <= 1'b0;
				end
				EV_OK: begin
					ty_o_q <= type_q;
					cm_o_q <= cmd_q;
					dc_o_q <= dcount_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = ev_q;
	assign frame_type = ty_o_q;
	assign command    = cm_o_q;
	assign data_byte  = db_o_q;
	assign data_index = di_o_q;
	assign data_count = dc_o_q;
	assign last       = last_o_q;

endmodule

/* hdl/serial_api_frame_parser_core.sv */
// Serial API frame parser top level: controller plus datapath.
// Depends on safp_pkg, safp_ctrl, safp_dp and the assertion macro header.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   config   | cfg_wr_en            | cfg_index, cfg_data
//   input    | in_valid / in_ready  | rx_byte
//   result   | out_valid / out_ready| event_res, frame_type, command, data_byte,
//            |                      | data_index, data_count, last
//
// A received byte is registered in a hold register and handled once the
// output slot is free; a new byte is taken only after the held one is
// consumed. A good frame releases each data result with a store read, then an
// output load, then the summary. Reset is asynchronous, active low, and needs
// no clearing pass. A stalled result holds the output register; a new byte is
// still taken into the hold register and waits there until the slot frees.
`include "serial_api_frame_parser_core_defines.svh"

module serial_api_frame_parser_core #(
	parameter int unsigned MAX_DATA = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [safp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     event_res,
	output logic [7:0]                     frame_type,
	output logic [7:0]                     command,
	output logic [7:0]                     data_byte,
	output logic [4:0]                     data_index,
	output logic [5:0]                     data_count,
	output logic                           last
);
	import safp_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	safp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	safp_dp #(
		.MAX_DATA (MAX_DATA)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_res  (event_res),
		.frame_type (frame_type),
		.command    (command),
		.data_byte  (data_byte),
		.data_index (data_index),
		.data_count (data_count),
		.last       (last),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Only data results may be non-final
	`SAFP_ASSERT_IMPL(a_nonlast_is_data, out_valid && !last, event_res == EV_DATA)
	// Data results are never final
	`SAFP_ASSERT_IMPL(a_data_not_last, out_valid && event_res == EV_DATA, !last)
	// Released index stays inside the frame data
	`SAFP_ASSERT_IMPL(a_index_in_range, out_valid && event_res == EV_DATA, ({1'b0, data_index} < data_count))
	// Hold register is full right after a byte is taken
	`SAFP_ASSERT_NEXT(a_hold_full, in_valid && in_ready, !in_ready)

endmodule
